FILE: src/txcw_pkg.sv
`default_nettype none
package txcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;

	localparam int CHAR_W  = 8;
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int ADDR_W  = 11;
	localparam int RAM_AW  = $clog2(CELLS);

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	localparam logic REQ_PUT  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_RUN,
		ST_READ
	} txcw_state_t;

endpackage
`default_nettype wire

FILE: src/txcw_ram.sv
`default_nettype none
module txcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/text_console_writer_unit.sv
`default_nettype none
// channel | handshake          | payload
// in      | in_valid/in_ready  | req_type, char_code, read_address
// out     | out_valid/out_ready| read_char, cursor_col, cursor_row
//
// A put is answered straight from the run state; a read passes through the
// read state, as the character store has a registered read port. One item is in flight at a time.
// After reset, and after a put that leaves the last row, the store is swept
// to spaces one cell a cycle, all ROWS*COLUMNS (2000) cells, with in_ready low.
// A result waits in the output register; the next word is taken while it
// drains in the same cycle.
module text_console_writer_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           req_type,
	input  wire logic [txcw_pkg::CHAR_W-1:0]    char_code,
	input  wire logic [txcw_pkg::ADDR_W-1:0]    read_address,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [txcw_pkg::CHAR_W-1:0]    read_char,
	output logic      [txcw_pkg::COL_W-1:0]     cursor_col,
	output logic      [txcw_pkg::ROW_W-1:0]     cursor_row
);
	import txcw_pkg::*;

	txcw_state_t       state_q, state_d;
	logic [RAM_AW-1:0] clr_q, clr_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic              out_load;
	logic [CHAR_W-1:0] out_char_d;

	logic              mem_we, mem_re;
	logic [RAM_AW-1:0] mem_waddr;
	logic [CHAR_W-1:0] mem_wdata;
	logic [CHAR_W-1:0] mem_rdata;

	logic [ROW_W-1:0]  cell_row;
	logic [COL_W-1:0]  cell_col;
	logic [RAM_AW-1:0] cell_addr;
	logic              at_last_row, at_last_col, at_home;

	txcw_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(read_address[RAM_AW-1:0]),
		.rdata(mem_rdata)
	);

	assign at_last_row = (row_q == ROW_W'(ROWS - 1));
	assign at_last_col = (col_q == COL_W'(COLUMNS - 1));
	assign at_home     = (row_q == '0) && (col_q == '0);

	// backspace targets the cell before the cursor, everything else the cursor cell
	always_comb begin
		cell_row = row_q;
		cell_col = col_q;
		if (char_code == CH_BACKSPACE) begin
			if (col_q != '0) begin
				cell_col = col_q - COL_W'(1);
			end else begin
				cell_row = row_q - ROW_W'(1);
				cell_col = COL_W'(COLUMNS - 1);
			end
		end
	end

	assign cell_addr = RAM_AW'(RAM_AW'(cell_row) * RAM_AW'(COLUMNS)) + RAM_AW'(cell_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			col_q   <= col_d;
			row_q   <= row_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		col_d      = col_q;
		row_d      = row_q;
		in_ready   = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = clr_q;
		mem_wdata  = CH_SPACE;
		mem_re     = 1'b0;
		out_load   = 1'b0;
		out_char_d = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == RAM_AW'(CELLS - 1)) begin
					clr_d   = '0;
					state_d = ST_RUN;
				end else begin
					clr_d = clr_q + RAM_AW'(1);
				end
			end
			ST_RUN: begin
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					if (req_type == REQ_READ) begin
						if (read_address < ADDR_W'(CELLS)) begin
							mem_re  = 1'b1;
							state_d = ST_READ;
						end else begin
							out_load = 1'b1;
						end
					end else begin
						out_load  = 1'b1;
						mem_waddr = cell_addr;
						mem_wdata = char_code;
						if (char_code == CH_BACKSPACE) begin
							if (!at_home) begin
								mem_we    = 1'b1;
								mem_wdata = CH_SPACE;
								col_d     = cell_col;
								row_d     = cell_row;
							end
						end else begin
							if (char_code != CH_NEWLINE) begin
								mem_we = 1'b1;
							end
							if (char_code == CH_NEWLINE || at_last_col) begin
								col_d = '0;
								if (at_last_row) begin
									// off the bottom: home and wipe the screen
									row_d   = '0;
									clr_d   = '0;
									state_d = ST_CLEAR;
								end else begin
									row_d = row_q + ROW_W'(1);
								end
							end else begin
								col_d = col_q + COL_W'(1);
							end
						end
					end
				end
			end
			ST_READ: begin
				out_load   = 1'b1;
				out_char_d = mem_rdata;
				state_d    = ST_RUN;
			end
			default: begin
				state_d = ST_CLEAR;
				clr_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the word until it is taken
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q <= out_char_d;
			out_col_q  <= col_d;
			out_row_q  <= row_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_char  = out_char_q;
	assign cursor_col = out_col_q;
	assign cursor_row = out_row_q;

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
	import txcw_pkg::*;

	typedef struct packed {
		logic              req;
		logic [CHAR_W-1:0] ch;
		logic [ADDR_W-1:0] addr;
	} console_word_t;

	typedef struct packed {
		logic [CHAR_W-1:0] rd;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} screen_echo_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic              req_type     = REQ_PUT;
	logic [CHAR_W-1:0] char_code    = '0;
	logic [ADDR_W-1:0] read_address = '0;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	logic [CHAR_W-1:0] read_char;
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;

	console_word_t words_pending[$];
	screen_echo_t  echoes_due[$];

	// predicted screen and cursor
	logic [CHAR_W-1:0] screen_cells [CELLS];
	logic [COL_W-1:0]  cur_col;
	logic [ROW_W-1:0]  cur_row;

	int   send_idle_pct  = 30;
	int   recv_stall_pct = 50;
	logic hold_off       = 1'b0;
	int   words_in       = 0;
	int   errors         = 0;

	text_console_writer_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.char_code    (char_code),
		.read_address (read_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_char    (read_char),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task blank_screen();
		for (int i = 0; i < CELLS; i++)
			screen_cells[i] = CH_SPACE;
	endtask

	task line_feed();
		cur_col = '0;
		if (cur_row == ROWS - 1) begin
			blank_screen();
			cur_row = '0;
		end else begin
			cur_row++;
		end
	endtask

	task type_word(input console_word_t w, output screen_echo_t e);
		e.rd = '0;
		if (w.req == REQ_READ) begin
			if (w.addr < CELLS)
				e.rd = screen_cells[w.addr];
		end else if (w.ch == CH_NEWLINE) begin
			line_feed();
		end else if (w.ch == CH_BACKSPACE) begin
			if (cur_col != 0) begin
				cur_col--;
				screen_cells[cur_row * COLUMNS + cur_col] = CH_SPACE;
			end else if (cur_row != 0) begin
				// step back onto the last column of the row above
				cur_row--;
				cur_col = COL_W'(COLUMNS - 1);
				screen_cells[cur_row * COLUMNS + cur_col] = CH_SPACE;
			end
		end else begin
			screen_cells[cur_row * COLUMNS + cur_col] = w.ch;
			if (cur_col == COLUMNS - 1)
				line_feed();
			else
				cur_col++;
		end
		e.col = cur_col;
		e.row = cur_row;
	endtask

	task report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("tb: mismatch on %s at %0t: got 0x%0h, expected 0x%0h", what, $realtime, got,
			want);
	endtask

	task push_put(input logic [CHAR_W-1:0] c);
		words_pending.push_back('{REQ_PUT, c, ADDR_W'($urandom_range(0, 2047))});
	endtask

	task push_read(input logic [ADDR_W-1:0] a);
		words_pending.push_back('{REQ_READ, CHAR_W'($urandom_range(0, 255)), a});
	endtask

	// sequences of console traffic with random content
	task fill_random(input int count);
		int n;
		int len;
		int k;
		int r;
		n = 0;
		while (n < count) begin
			k = $urandom_range(0, 99);
			if (k < 35) begin
				len = $urandom_range(1, 60);
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(0, 99);
					if (r < 8)
						push_put(CH_NEWLINE);
					else if (r < 15)
						push_put(CH_BACKSPACE);
					else if (r < 25)
						push_read(ADDR_W'($urandom_range(0, CELLS - 1)));
					else
						push_put(CHAR_W'($urandom_range(0, 255)));
				end
			end else if (k < 50) begin
				len = $urandom_range(1, 30);
				repeat (len) push_put(CH_NEWLINE);
			end else if (k < 60) begin
				len = $urandom_range(1, 100);
				repeat (len) push_put(CH_BACKSPACE);
			end else if (k < 75) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 4) == 0)
						push_read(ADDR_W'($urandom_range(0, 2047)));
					else
						push_read(ADDR_W'($urandom_range(0, CELLS - 1)));
				end
			end else begin
				// a full line of text forces the wrap
				len = COLUMNS;
				repeat (len) push_put(CHAR_W'($urandom_range(8'h21, 8'h7E)));
			end
			n += len;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		screen_echo_t due;
		if (!arst_n) begin
			blank_screen();
			cur_col      = '0;
			cur_row      = '0;
			in_valid     <= 1'b0;
			req_type     <= REQ_PUT;
			char_code    <= '0;
			read_address <= '0;
		end else begin
			if (in_valid && in_ready) begin
				type_word('{req_type, char_code, read_address}, due);
				echoes_due.push_back(due);
				words_in <= words_in + 1;
			end
			// offer a new word only once the current one has gone
			if (!in_valid || in_ready) begin
				if (words_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid     <= 1'b1;
					req_type     <= words_pending[0].req;
					char_code    <= words_pending[0].ch;
					read_address <= words_pending[0].addr;
					void'(words_pending.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		screen_echo_t due;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (echoes_due.size() == 0) begin
					report_mismatch("result with none pending", read_char, 0);
				end else begin
					due = echoes_due.pop_front();
					if (read_char !== due.rd)
						report_mismatch("read_char", read_char, due.rd);
					if (cursor_col !== due.col)
						report_mismatch("cursor_col", cursor_col, due.col);
					if (cursor_row !== due.row)
						report_mismatch("cursor_row", cursor_row, due.row);
				end
			end
			out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// hold the output back long enough for the input to back up
	initial begin
		wait (words_in >= 100);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_put(CH_BACKSPACE);     // backspace at home
		push_read(ADDR_W'(0));
		push_put(8'h41);
		push_put(8'h00);
		push_put(8'hFF);
		push_put(CH_BACKSPACE);     // backspace mid-row
		push_read(ADDR_W'(1));
		push_read(ADDR_W'(2));
		push_put(CH_NEWLINE);
		push_put(CH_BACKSPACE);     // back over the row boundary
		push_put(8'h5A);            // last column, wraps
		push_read(ADDR_W'(COLUMNS - 1));
		push_read(ADDR_W'(CELLS - 1));
		push_read(ADDR_W'(CELLS));
		push_read(ADDR_W'(2047));
		push_read(ADDR_W'(1024));
		repeat (ROWS) push_put(CH_NEWLINE);  // run off the bottom
		push_read(ADDR_W'(0));

		for (int ph = 0; ph < 3; ph++) begin
			if (ph > 0) begin
				while (words_pending.size() != 0) @(posedge clk);
				@(posedge clk);
				send_idle_pct  <= (ph == 1) ? 50 : 0;
				recv_stall_pct <= (ph == 1) ? 30 : 0;
				@(negedge clk);
			end
			fill_random(230);
		end

		while (words_pending.size() != 0 || in_valid) @(posedge clk);
		while (echoes_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#10ms;
		$display("tb: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
src/txcw_pkg.sv
src/txcw_ram.sv
src/text_console_writer_unit.sv
test/tb.sv
